@@ sv/wma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_pkg
// Shared widths, register indexes and types of the weighted moving average.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int PRICE_W      = 32;
    localparam int WEIGHT_W     = 17;
    localparam int LEN_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_WEIGHTS  = 7;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_TAPS_DEF = 7;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PROD_W       = PRICE_W + WEIGHT_W;
    localparam int TREE_SLOTS   = 8;
    localparam int SUM_W        = PROD_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEWEST = 3'd1;

    typedef logic [PRICE_W-1:0]  t_price;
    typedef logic [WEIGHT_W-1:0] t_weight;

    localparam t_weight WEIGHT_ONE = 17'h10000;

    typedef struct packed {
        logic [LEN_W-1:0]             len;
        t_weight [NUM_WEIGHTS-1:0]    weight;
    } t_cfg;

endpackage

@@ sv/wma_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_if
// Valid/ready stream interfaces for prices in and averages out.
// ----------------------------------------------------------------------------
interface wma_price_if;
    logic            valid;
    logic            ready;
    wma_pkg::t_price close_price;

    modport source (output valid, output close_price, input ready);
    modport sink   (input valid, input close_price, output ready);
endinterface

interface wma_avg_if;
    logic            valid;
    logic            ready;
    wma_pkg::t_price average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

@@ sv/wma_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_queue
// Small fifo of window snapshots between the front and the back end.
// ----------------------------------------------------------------------------
module wma_queue #(
    parameter int DATA_W = 224,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full    = (r_count == DepthCnt);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DepthCnt)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("push without pop did not grow the queue");

endmodule

@@ sv/wma_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_front
// Accepts prices, shifts the window and decides which words yield an average.
// ----------------------------------------------------------------------------
module wma_front #(
    parameter int MAX_TAPS = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [wma_pkg::LEN_W-1:0]          i_len,
    wma_price_if.sink                          i_price,
    input  logic                               i_q_full,
    output logic                               o_push,
    output logic [MAX_TAPS*wma_pkg::PRICE_W-1:0] o_push_data
);
    import wma_pkg::*;

    localparam logic [LEN_W-1:0] MaxTapsLen = LEN_W'(MAX_TAPS);

    t_price           r_win [MAX_TAPS];
    t_price           n_win [MAX_TAPS];
    logic [LEN_W-1:0] r_fill, n_fill;
    logic             in_fire;
    logic             emit;

    assign i_price.ready = !i_q_full;
    assign in_fire       = i_price.valid && i_price.ready;

    always_comb begin
        n_win[0] = i_price.close_price;
        for (int k = 1; k < MAX_TAPS; k++) begin
            n_win[k] = r_win[k-1];
        end
        for (int k = 0; k < MAX_TAPS; k++) begin
            o_push_data[k*PRICE_W +: PRICE_W] = n_win[k];
        end
    end

    // fill climbs until the window is full; results start on the filling word
    always_comb begin
        if (r_fill < i_len) begin
            n_fill = r_fill + 1'b1;
            emit   = (n_fill == i_len);
        end else begin
            n_fill = r_fill;
            emit   = 1'b1;
        end
    end

    assign o_push = in_fire && emit;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (in_fire) begin
            r_fill <= n_fill;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MaxTapsLen)
        else $error("fill count beyond tap count");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_fill < i_len)) |=> r_fill == $past(r_fill) + 1'b1)
        else $error("fill count did not advance");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("push into full queue");

endmodule

@@ sv/wma_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_back
// Multiplies the window by the weights, sums in a registered tree, scales
// and saturates, and holds the average in the output register.
// ----------------------------------------------------------------------------
module wma_back #(
    parameter int MAX_TAPS = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wma_pkg::t_cfg                        i_cfg,
    input  logic                                 i_q_empty,
    input  logic [MAX_TAPS*wma_pkg::PRICE_W-1:0] i_q_data,
    output logic                                 o_pop,
    wma_avg_if.source                            o_avg
);
    import wma_pkg::*;

    logic                advance;
    logic [PROD_W-1:0]   n_prod [TREE_SLOTS];
    logic [PROD_W-1:0]   r_prod [TREE_SLOTS];
    logic [PROD_W:0]     r_sum2 [TREE_SLOTS/2];
    logic [PROD_W+1:0]   r_sum3 [TREE_SLOTS/4];
    logic [SUM_W-1:0]    total;
    logic [SUM_W-FRAC_BITS-1:0] scaled;
    t_price              n_avg;
    t_price              r_avg;
    logic                r_s1_v, r_s2_v, r_s3_v, r_out_v;

    // whole pipeline moves when the output register is free or being taken
    assign advance = !r_out_v || o_avg.ready;
    assign o_pop   = advance && !i_q_empty;

    always_comb begin
        for (int k = 0; k < TREE_SLOTS; k++) begin
            n_prod[k] = '0;
        end
        for (int k = 0; k < MAX_TAPS; k++) begin
            if (LEN_W'(k) < i_cfg.len) begin
                n_prod[k] = PROD_W'(i_q_data[k*PRICE_W +: PRICE_W])
                          * PROD_W'(i_cfg.weight[k]);
            end
        end
    end

    always_comb begin
        total  = SUM_W'(r_sum3[0]) + SUM_W'(r_sum3[1]);
        scaled = total[SUM_W-1:FRAC_BITS];
        if (|scaled[SUM_W-FRAC_BITS-1:PRICE_W]) begin
            n_avg = '1;
        end else begin
            n_avg = scaled[PRICE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_prod <= n_prod;
            for (int k = 0; k < TREE_SLOTS/2; k++) begin
                r_sum2[k] <= (PROD_W+1)'(r_prod[2*k]) + (PROD_W+1)'(r_prod[2*k+1]);
            end
            for (int k = 0; k < TREE_SLOTS/4; k++) begin
                r_sum3[k] <= (PROD_W+2)'(r_sum2[2*k]) + (PROD_W+2)'(r_sum2[2*k+1]);
            end
            if (r_s3_v) begin
                r_avg <= n_avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_s1_v  <= !i_q_empty;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    assign o_avg.valid   = r_out_v;
    assign o_avg.average = r_avg;

endmodule

@@ sv/weighted_moving_average_core.sv @@
`timescale 1ns / 1ps
// an average passes the queue, then r_prod, r_sum2, r_sum3 and r_avg before it is offered
// throughput: one price word per cycle while the queue is not full; every tap has its own multiplier
// the queue absorbs two words while the output stage is stalled
// reset clears the fill count and all valid bits and restores the registers
// (window length 1, newest weight 1.0); stored prices are not cleared
// ----------------------------------------------------------------------------
// weighted_moving_average_core
// Weighted moving average over a configurable window of closing prices.
// ----------------------------------------------------------------------------
module weighted_moving_average_core #(
    parameter int MAX_TAPS = wma_pkg::MAX_TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wma_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wma_pkg::WEIGHT_W-1:0]      i_cfg_data,
    wma_price_if.sink                         i_price,
    wma_avg_if.source                         o_avg
);
    import wma_pkg::*;

    localparam int WIN_W = MAX_TAPS * PRICE_W;
    localparam logic [LEN_W-1:0] MaxTapsLen = LEN_W'(MAX_TAPS);

    logic [LEN_W-1:0] r_len_raw;
    t_weight          r_weight [NUM_WEIGHTS];
    t_cfg             cfg;
    logic             q_push, q_pop, q_full, q_empty;
    logic [WIN_W-1:0] q_push_data, q_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_raw <= LEN_W'(1);
            for (int k = 0; k < NUM_WEIGHTS; k++) begin
                r_weight[k] <= (k == 0) ? WEIGHT_ONE : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WINDOW_LENGTH) begin
                r_len_raw <= i_cfg_data[LEN_W-1:0];
            end else begin
                r_weight[CFG_IDX_W'(i_cfg_idx - REG_WEIGHT_NEWEST)] <= i_cfg_data;
            end
        end
    end

    // zero length acts as one, anything past the tap count is clamped
    always_comb begin
        if (r_len_raw == '0) begin
            cfg.len = LEN_W'(1);
        end else if (r_len_raw > MaxTapsLen) begin
            cfg.len = MaxTapsLen;
        end else begin
            cfg.len = r_len_raw;
        end
        for (int k = 0; k < NUM_WEIGHTS; k++) begin
            cfg.weight[k] = r_weight[k];
        end
    end

    wma_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (cfg.len),
        .i_price     (i_price),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    wma_queue #(
        .DATA_W (WIN_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_rd_data   (q_rd_data)
    );

    wma_back #(
        .MAX_TAPS (MAX_TAPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_pop     (q_pop),
        .o_avg     (o_avg)
    );

endmodule

@@ sim/weighted_moving_average_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_moving_average_core_tb
// Drives price words into the weighted moving average core and compares every
// average word with a cycle-free predictor. A directed table covers register
// extremes, zero and full windows, shrinking and growing windows and
// saturation. Random phases then follow, each with its own register setting
// and a mix of sender gaps and receiver stalls that repeats every four phases.
// ----------------------------------------------------------------------------
module weighted_moving_average_core_tb;

    import wma_pkg::*;

    localparam int MAX_TAPS        = MAX_TAPS_DEF;
    localparam int DRAIN_CYCLES    = 10;
    localparam int STUCK_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_PHASE      = 4;
    localparam int PAUSE_PHASE     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AGE1 = REG_WEIGHT_NEWEST + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AGE2 = REG_WEIGHT_NEWEST + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AGE3 = REG_WEIGHT_NEWEST + 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AGE4 = REG_WEIGHT_NEWEST + 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AGE5 = REG_WEIGHT_NEWEST + 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AGE6 = REG_WEIGHT_NEWEST + 3'd6;

    typedef enum logic {ROW_CFG, ROW_PRICE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [31:0]            value;
        bit                     typed;
        t_price                 expected;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 38;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_PRICE, '0, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_PRICE, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{ROW_PRICE, '0, 32'h5A5A_C3C3, 1'b1, 32'h5A5A_C3C3},
        '{ROW_CFG, REG_WEIGHT_NEWEST, 32'h1_FFFF, 1'b0, '0},
        '{ROW_PRICE, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{ROW_PRICE, '0, 32'h0000_0001, 1'b1, 32'h0000_0001},
        '{ROW_CFG, REG_WEIGHT_NEWEST, 32'h0, 1'b0, '0},
        '{ROW_PRICE, '0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        // zero length behaves as a one-price window
        '{ROW_CFG, REG_WINDOW_LENGTH, 32'h0, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_NEWEST, 32'h1_0000, 1'b0, '0},
        '{ROW_PRICE, '0, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5},
        // grow to the full window: five silent words, then results
        '{ROW_CFG, REG_WINDOW_LENGTH, 32'h7, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_NEWEST, 32'h4000, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE1, 32'h2000, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE2, 32'h1000, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE3, 32'h0800, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE4, 32'h0400, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE5, 32'h0200, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE6, 32'h0100, 1'b0, '0},
        '{ROW_PRICE, '0, 32'h0000_0010, 1'b0, '0},
        '{ROW_PRICE, '0, 32'hFFFF_0000, 1'b0, '0},
        '{ROW_PRICE, '0, 32'h0000_FFFF, 1'b0, '0},
        '{ROW_PRICE, '0, 32'h8000_0000, 1'b0, '0},
        '{ROW_PRICE, '0, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_PRICE, '0, 32'h1234_5678, 1'b0, '0},
        '{ROW_PRICE, '0, 32'hDEAD_BEEF, 1'b0, '0},
        // shrink keeps the fill count, so results go on every word
        '{ROW_CFG, REG_WINDOW_LENGTH, 32'h3, 1'b0, '0},
        '{ROW_PRICE, '0, 32'hCAFE_F00D, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_LENGTH, 32'h7, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_NEWEST, 32'h1_FFFF, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE1, 32'h1_FFFF, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE2, 32'h1_FFFF, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE3, 32'h1_FFFF, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE4, 32'h1_FFFF, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE5, 32'h1_FFFF, 1'b0, '0},
        '{ROW_CFG, REG_WEIGHT_AGE6, 32'h1_FFFF, 1'b0, '0},
        '{ROW_PRICE, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{ROW_PRICE, '0, 32'h0000_0000, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WEIGHT_W-1:0]  i_cfg_data;

    wma_price_if price_if();
    wma_avg_if   avg_if();

    weighted_moving_average_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_price    (price_if),
        .o_avg      (avg_if)
    );

    // predictor state
    t_price          price_hist [MAX_TAPS];
    logic [LEN_W-1:0] filled;
    logic [LEN_W-1:0] win_len_cfg;
    t_weight         weight_cfg [NUM_WEIGHTS];

    t_price expected_averages [$];
    int     mismatches = 0;
    int     send_idle_pct;
    int     rx_stall_pct;
    int     hold_requests;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     stuck_cycles = 0;

    always #5 i_clk = ~i_clk;

    // shift the price in and form the weighted sum; returns 1 if a word is due
    function automatic bit predict_average(input t_price price, output t_price avg);
        int unsigned len;
        int          k;
        logic [63:0] acc;
        bit          emit;
        len  = (win_len_cfg == '0) ? 1 : win_len_cfg;
        emit = 1'b1;
        if (filled < len) begin
            filled = filled + 1'b1;
            emit   = (filled == len);
        end
        for (k = MAX_TAPS - 1; k > 0; k--) begin
            price_hist[k] = price_hist[k-1];
        end
        price_hist[0] = price;
        acc = '0;
        for (k = 0; k < len; k++) begin
            acc += 64'(price_hist[k]) * 64'(weight_cfg[k]);
        end
        acc = acc >> FRAC_BITS;
        avg = (acc > 64'hFFFF_FFFF) ? '1 : acc[PRICE_W-1:0];
        return emit;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_weight data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WINDOW_LENGTH) begin
            win_len_cfg = data[LEN_W-1:0];
        end else begin
            weight_cfg[idx - REG_WEIGHT_NEWEST] = data;
        end
        @(posedge i_clk);
    endtask

    // valid stays high after acceptance so back-to-back words need one assignment
    task automatic send_price(input t_price price, input bit typed, input t_price typed_avg);
        t_price avg;
        while ($urandom_range(99) < send_idle_pct) begin
            price_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        price_if.valid       <= 1'b1;
        price_if.close_price <= price;
        do @(posedge i_clk); while (!price_if.ready);
        if (predict_average(price, avg)) begin
            expected_averages = {expected_averages, (typed ? typed_avg : avg)};
        end
    endtask

    task automatic wait_drained(input int settle);
        price_if.valid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // average word checker and receiver stall generation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            avg_if.ready <= 1'b0;
        end else begin
            if (avg_if.valid && avg_if.ready) begin
                if (expected_averages.size() == 0) begin
                    $display("%0t: unexpected average word %h", $time, avg_if.average);
                    mismatches++;
                end else begin
                    if (avg_if.average !== expected_averages[0]) begin
                        $display("%0t: average mismatch: expected %h, actual %h",
                                 $time, expected_averages[0], avg_if.average);
                        mismatches++;
                    end
                    void'(expected_averages.pop_front());
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                avg_if.ready <= 1'b0;
            end else begin
                avg_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((price_if.valid && price_if.ready) || (avg_if.valid && avg_if.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int               row;
        int               phase;
        int               n;
        int               k;
        int               pick;
        logic [LEN_W-1:0] new_len;
        t_weight          w;
        t_price           price;

        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        price_if.valid       = 1'b0;
        price_if.close_price = '0;
        send_idle_pct        = 0;
        rx_stall_pct         = 0;
        hold_requests        = 0;
        filled               = '0;
        win_len_cfg          = LEN_W'(1);
        for (k = 0; k < NUM_WEIGHTS; k++) begin
            weight_cfg[k] = '0;
        end
        weight_cfg[0] = WEIGHT_ONE;
        for (k = 0; k < MAX_TAPS; k++) begin
            price_hist[k] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_CFG) begin
                wait_drained(DRAIN_CYCLES);
                write_reg(directed_rows[row].reg_idx, directed_rows[row].value[WEIGHT_W-1:0]);
            end else begin
                send_price(directed_rows[row].value, directed_rows[row].typed,
                           directed_rows[row].expected);
            end
        end
        wait_drained(DRAIN_CYCLES);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    rx_stall_pct  = 0;
                end
                1: begin
                    send_idle_pct = 65;
                    rx_stall_pct  = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    rx_stall_pct  = 65;
                end
                default: begin
                    send_idle_pct = 33;
                    rx_stall_pct  = 33;
                end
            endcase

            // phases 0 to 2 pin the length and phases 0 and 1 the weights; the rest pick at random
            if (phase == 0) begin
                new_len = LEN_W'(MAX_TAPS);
            end else if (phase == 1) begin
                new_len = LEN_W'(1);
            end else if (phase == 2) begin
                new_len = '0;
            end else begin
                new_len = LEN_W'($urandom_range(0, 7));
            end
            write_reg(REG_WINDOW_LENGTH, t_weight'(new_len));
            for (k = 0; k < NUM_WEIGHTS; k++) begin
                if (phase == 0) begin
                    w = '1;
                end else if (phase == 1) begin
                    w = (k == 0) ? WEIGHT_ONE : '0;
                end else if ($urandom_range(3) == 0) begin
                    w = t_weight'($urandom);
                end else begin
                    w = t_weight'($urandom_range(0, WEIGHT_ONE));
                end
                write_reg(REG_WEIGHT_NEWEST + CFG_IDX_W'(k), w);
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold while words keep coming, so the input backs up
                if (phase == HOLD_PHASE && n == 40) begin
                    hold_requests++;
                end
                if (phase == PAUSE_PHASE && n == 100) begin
                    wait_drained(0);
                end
                pick = $urandom_range(9);
                if (pick == 0) begin
                    price = '0;
                end else if (pick == 1) begin
                    price = '1;
                end else if (pick < 4) begin
                    price = t_price'($urandom_range(0, 1000));
                end else begin
                    price = t_price'($urandom);
                end
                send_price(price, 1'b0, '0);
            end
            wait_drained(DRAIN_CYCLES);
        end

        if (mismatches == 0 && expected_averages.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
